// File: sv/fewc_pkg.sv
`default_nettype none

package fewc_pkg;

    // default geometry
    localparam int UNIT_COUNT_DEF     = 256;
    localparam int UNIT_SIZE_LOG2_DEF = 12;

    // field widths
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 24;
    localparam int CFG_W   = 16;

    // counter encodings
    localparam logic [COUNT_W-1:0] NEVER_COUNTED = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_CAP     = 16'hFFFE;
    localparam logic [TOTAL_W-1:0] TOTAL_CAP     = 24'hFFFFFF;

    // register reset values
    localparam logic [15:0] FLUSH_THR_RST = 16'd64;
    localparam logic [7:0]  IDLE_THR_RST  = 8'd60;

    // register indexes
    localparam logic CFG_IDX_FLUSH_THR = 1'b0;
    localparam logic CFG_IDX_IDLE_THR  = 1'b1;

    typedef enum logic [2:0] {
        CMD_CLEAR        = 3'd0,
        CMD_LOAD_ENTRY   = 3'd1,
        CMD_LOAD_DONE    = 3'd2,
        CMD_COUNT_ERASE  = 3'd3,
        CMD_FLUSH_VISIT  = 3'd4,
        CMD_FLUSH_RESULT = 3'd5,
        CMD_SPAN_QUERY   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT_CLEAR,
        ST_IDLE,
        ST_CLEAR,
        ST_RMW,
        ST_SPAN,
        ST_RESP
    } state_t;

    // control from the sequencer to the span accumulator
    typedef struct packed {
        logic clr;
        logic acc;
    } span_ctl_t;

endpackage

`default_nettype wire

// File: sv/fewc_store.sv
`default_nettype none

module fewc_store
    import fewc_pkg::*;
#(
    parameter int DEPTH = UNIT_COUNT_DEF,
    parameter int AW    = 8
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [COUNT_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [COUNT_W-1:0] rd_data
);

    logic [COUNT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/fewc_span.sv
`default_nettype none

module fewc_span
    import fewc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire span_ctl_t          ctl,
    input  wire logic [COUNT_W-1:0] rd_data,
    output logic      [COUNT_W-1:0] span_max,
    output logic      [TOTAL_W-1:0] span_total
);

    logic [COUNT_W-1:0] max_reg, max_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [TOTAL_W:0]   sum_wide;

    // running maximum and saturating sum
    always_comb begin
        max_next = max_reg;
        sum_next = sum_reg;
        sum_wide = {1'b0, sum_reg} + (TOTAL_W + 1)'(rd_data);
        if (ctl.clr) begin
            max_next = '0;
            sum_next = '0;
        end else if (ctl.acc) begin
            if (rd_data > max_reg) begin
                max_next = rd_data;
            end
            if (sum_wide > {1'b0, TOTAL_CAP}) begin
                sum_next = TOTAL_CAP;
            end else begin
                sum_next = sum_wide[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            sum_reg <= '0;
        end else begin
            max_reg <= max_next;
            sum_reg <= sum_next;
        end
    end

    assign span_max   = max_reg;
    assign span_total = sum_reg;

endmodule

`default_nettype wire

// File: sv/flash_erase_wear_counter.sv
`default_nettype none

// Erase wear counter: one 16-bit saturating counter per flash unit, kept in a
// single-port-write, registered-read memory, plus an unsaved-erase count and
// write-back bookkeeping. One transaction is worked at a time and yields one
// result; the result sits in an output register, so the next transaction is
// taken while it waits. Count erase reads the counter, then modifies and
// writes it back. A span query makes one memory read per table unit that it
// covers. Clear and a failed load done sweep the memory one entry per cycle.
// After reset the same clearing pass runs, during which s_ready stays low;
// configuration writes are taken at any time.
module flash_erase_wear_counter
    import fewc_pkg::*;
#(
    parameter int UNIT_COUNT     = UNIT_COUNT_DEF,
    parameter int UNIT_SIZE_LOG2 = UNIT_SIZE_LOG2_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [31:0]        s_address,
    input  wire logic [31:0]        s_span_length,
    input  wire logic [7:0]         s_unit_index,
    input  wire logic [15:0]        s_load_value,
    input  wire logic               s_idle_flag,
    input  wire logic               s_ok_flag,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_flush_request,
    output logic      [COUNT_W-1:0] m_span_max,
    output logic      [TOTAL_W-1:0] m_span_total,
    output logic      [31:0]        m_unsaved_count,
    output logic                    m_counting_enabled
);

    localparam int AW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int CW = $clog2(UNIT_COUNT + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(UNIT_COUNT - 1);
    localparam logic [CW-1:0] UC_CW    = CW'(UNIT_COUNT);
    localparam logic [32:0]   ROUND_UP = 33'((64'd1 << UNIT_SIZE_LOG2) - 64'd1);

    state_t state_reg, state_next;

    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] end_reg, end_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [31:0]   unsaved_reg, unsaved_next;
    logic [7:0]    ticks_reg, ticks_next;
    logic          loaded_reg, loaded_next;
    logic          flushing_reg, flushing_next;
    logic          request_reg, request_next;
    logic [15:0]   flush_thr_reg;
    logic [7:0]    idle_thr_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_req_reg;
    logic [COUNT_W-1:0] out_max_reg;
    logic [TOTAL_W-1:0] out_sum_reg;
    logic [31:0]        out_unsaved_reg;
    logic               out_loaded_reg;
    logic               out_load;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [COUNT_W-1:0] mem_rdata;

    span_ctl_t          span_ctl;
    logic [COUNT_W-1:0] span_max;
    logic [TOTAL_W-1:0] span_total;

    logic          accept;
    logic [31:0]   unit32;
    logic          unit_in_range;
    logic [31:0]   load_idx32;
    logic [32:0]   span_units;
    logic [33:0]   span_end;
    logic [7:0]    ticks_upd;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // address decode shared by count erase and span query, plus load index and idle tick update
    assign unit32        = s_address >> UNIT_SIZE_LOG2;
    assign unit_in_range = (unit32 < 32'(UNIT_COUNT));
    assign load_idx32    = 32'(s_unit_index);
    assign span_units    = ({1'b0, s_span_length} + ROUND_UP) >> UNIT_SIZE_LOG2;
    assign span_end      = {2'b00, unit32} + {1'b0, span_units};
    assign ticks_upd     = s_idle_flag ? ((ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1)
                                       : 8'd0;

    // sequencer: next state, bookkeeping and memory accesses
    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        rd_pend_next  = rd_pend_reg;
        unsaved_next  = unsaved_reg;
        ticks_next    = ticks_reg;
        loaded_next   = loaded_reg;
        flushing_next = flushing_reg;
        request_next  = request_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg[AW-1:0];
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg[AW-1:0];
        span_ctl.clr  = accept;
        span_ctl.acc  = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_INIT_CLEAR, ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (ptr_reg == LAST_IDX) begin
                    ptr_next   = '0;
                    state_next = (state_reg == ST_CLEAR) ? ST_RESP : ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    request_next = 1'b0;
                    state_next   = ST_RESP;
                    case (cmd_t'(s_cmd))
                        CMD_CLEAR: begin
                            unsaved_next  = '0;
                            ticks_next    = '0;
                            loaded_next   = 1'b0;
                            flushing_next = 1'b0;
                            ptr_next      = '0;
                            state_next    = ST_CLEAR;
                        end
                        CMD_LOAD_ENTRY: begin
                            if (load_idx32 < 32'(UNIT_COUNT)) begin
                                mem_we    = 1'b1;
                                mem_waddr = load_idx32[AW-1:0];
                                mem_wdata = (s_load_value == NEVER_COUNTED) ? '0
                                                                            : s_load_value;
                            end
                        end
                        CMD_LOAD_DONE: begin
                            if (s_ok_flag) begin
                                loaded_next = 1'b1;
                            end else begin
                                loaded_next = 1'b0;
                                ptr_next    = '0;
                                state_next  = ST_CLEAR;
                            end
                        end
                        CMD_COUNT_ERASE: begin
                            if (loaded_reg && unit_in_range) begin
                                mem_re     = 1'b1;
                                mem_raddr  = unit32[AW-1:0];
                                ptr_next   = unit32[CW-1:0];
                                state_next = ST_RMW;
                            end
                        end
                        CMD_FLUSH_VISIT: begin
                            if (!loaded_reg || unsaved_reg == '0 || flushing_reg) begin
                                ticks_next = '0;
                            end else if (unsaved_reg >= 32'(flush_thr_reg)
                                         || ticks_upd >= idle_thr_reg) begin
                                flushing_next = 1'b1;
                                ticks_next    = '0;
                                request_next  = 1'b1;
                            end else begin
                                ticks_next = ticks_upd;
                            end
                        end
                        CMD_FLUSH_RESULT: begin
                            if (flushing_reg) begin
                                if (s_ok_flag) begin
                                    unsaved_next = '0;
                                end else begin
                                    loaded_next = 1'b0;
                                end
                                flushing_next = 1'b0;
                                ticks_next    = '0;
                            end
                        end
                        CMD_SPAN_QUERY: begin
                            ptr_next     = unit_in_range ? unit32[CW-1:0] : UC_CW;
                            end_next     = (span_end > 34'(UNIT_COUNT)) ? UC_CW
                                                                        : span_end[CW-1:0];
                            rd_pend_next = 1'b0;
                            state_next   = ST_SPAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // read data of the counter is here, write back the bumped value
            ST_RMW: begin
                mem_we       = 1'b1;
                mem_waddr    = ptr_reg[AW-1:0];
                mem_wdata    = (mem_rdata < COUNT_CAP) ? mem_rdata + COUNT_W'(1) : mem_rdata;
                unsaved_next = unsaved_reg + 32'd1;
                state_next   = ST_RESP;
            end

            // one read issued per cycle, accumulated in the cycle after
            ST_SPAN: begin
                span_ctl.acc = rd_pend_reg;
                if (ptr_reg < end_reg) begin
                    mem_re       = 1'b1;
                    mem_raddr    = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg) begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT_CLEAR;
            ptr_reg      <= '0;
            end_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            unsaved_reg  <= '0;
            ticks_reg    <= '0;
            loaded_reg   <= 1'b0;
            flushing_reg <= 1'b0;
            request_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            end_reg      <= end_next;
            rd_pend_reg  <= rd_pend_next;
            unsaved_reg  <= unsaved_next;
            ticks_reg    <= ticks_next;
            loaded_reg   <= loaded_next;
            flushing_reg <= flushing_next;
            request_reg  <= request_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_thr_reg <= FLUSH_THR_RST;
            idle_thr_reg  <= IDLE_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_FLUSH_THR: flush_thr_reg <= cfg_wr_data[15:0];
                CFG_IDX_IDLE_THR:  idle_thr_reg  <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_req_reg     <= request_reg;
            out_max_reg     <= span_max;
            out_sum_reg     <= span_total;
            out_unsaved_reg <= unsaved_reg;
            out_loaded_reg  <= loaded_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_flush_request    = out_req_reg;
    assign m_span_max         = out_max_reg;
    assign m_span_total       = out_sum_reg;
    assign m_unsaved_count    = out_unsaved_reg;
    assign m_counting_enabled = out_loaded_reg;

    fewc_store #(
        .DEPTH (UNIT_COUNT),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    fewc_span u_span (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (span_ctl),
        .rd_data    (mem_rdata),
        .span_max   (span_max),
        .span_total (span_total)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fewc_pkg::*;

    localparam int UNITS = UNIT_COUNT_DEF;
    localparam int USZ   = UNIT_SIZE_LOG2_DEF;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] address;
        logic [31:0] span_length;
        logic [7:0]  unit_index;
        logic [15:0] load_value;
        logic        idle_flag;
        logic        ok_flag;
    } wear_item_t;

    typedef struct packed {
        logic               flush_request;
        logic [COUNT_W-1:0] span_max;
        logic [TOTAL_W-1:0] span_total;
        logic [31:0]        unsaved_count;
        logic               counting_enabled;
    } wear_result_t;

    // clock, reset and dut ports
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_index   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd = '0;
    logic [31:0]        s_address = '0;
    logic [31:0]        s_span_length = '0;
    logic [7:0]         s_unit_index = '0;
    logic [15:0]        s_load_value = '0;
    logic               s_idle_flag = 1'b0;
    logic               s_ok_flag = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_flush_request;
    logic [COUNT_W-1:0] m_span_max;
    logic [TOTAL_W-1:0] m_span_total;
    logic [31:0]        m_unsaved_count;
    logic               m_counting_enabled;

    // wear state mirrored by the predictor
    logic [15:0] wear_counts [UNITS];
    logic [31:0] wear_unsaved;
    logic [7:0]  wear_ticks;
    logic        wear_loaded;
    logic        wear_flushing;
    logic [15:0] flush_thr_reg;
    logic [7:0]  idle_thr_reg;

    // results still owed by the dut, oldest first
    wear_result_t due_results [$];
    logic [7:0]   hot_units [$];

    int mismatch_count;
    int results_checked;
    int requests_predicted;
    int spans_predicted;
    int tx_calm_left;
    int rx_calm_left;
    int rx_stall_left;
    int rx_stall;
    wear_result_t want;
    wear_result_t got;

    flash_erase_wear_counter u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_address          (s_address),
        .s_span_length      (s_span_length),
        .s_unit_index       (s_unit_index),
        .s_load_value       (s_load_value),
        .s_idle_flag        (s_idle_flag),
        .s_ok_flag          (s_ok_flag),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_flush_request    (m_flush_request),
        .m_span_max         (m_span_max),
        .m_span_total       (m_span_total),
        .m_unsaved_count    (m_unsaved_count),
        .m_counting_enabled (m_counting_enabled)
    );

    initial forever #2 aclk = ~aclk;

    // run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------
    // wear predictor
    // ---------------------------------------------------------------

    function automatic void wipe_wear_counts();
        for (int k = 0; k < UNITS; k++) begin
            wear_counts[k] = '0;
        end
    endfunction

    function automatic wear_result_t predict_wear(input wear_item_t it);
        wear_result_t    res;
        logic [19:0]     unit;
        logic [32:0]     rounded;
        longint unsigned first;
        longint unsigned stop;
        longint unsigned i;
        logic [31:0]     total;
        res = '0;
        unit = 20'(it.address >> USZ);
        case (it.cmd)
            CMD_CLEAR: begin
                wipe_wear_counts();
                wear_unsaved  = '0;
                wear_ticks    = '0;
                wear_loaded   = 1'b0;
                wear_flushing = 1'b0;
            end
            CMD_LOAD_ENTRY: begin
                if (it.unit_index < UNITS) begin
                    wear_counts[it.unit_index] =
                        (it.load_value == NEVER_COUNTED) ? 16'd0 : it.load_value;
                end
            end
            CMD_LOAD_DONE: begin
                // a failed commit throws the loaded table away
                if (it.ok_flag) begin
                    wear_loaded = 1'b1;
                end else begin
                    wipe_wear_counts();
                    wear_loaded = 1'b0;
                end
            end
            CMD_COUNT_ERASE: begin
                if (wear_loaded && unit < UNITS) begin
                    if (wear_counts[unit] < COUNT_CAP) begin
                        wear_counts[unit] = wear_counts[unit] + 16'd1;
                    end
                    wear_unsaved = wear_unsaved + 32'd1;
                end
            end
            CMD_FLUSH_VISIT: begin
                if (!wear_loaded || wear_unsaved == 0 || wear_flushing) begin
                    wear_ticks = '0;
                end else begin
                    if (it.idle_flag) begin
                        if (wear_ticks != 8'hFF) begin
                            wear_ticks = wear_ticks + 8'd1;
                        end
                    end else begin
                        wear_ticks = '0;
                    end
                    if (wear_unsaved >= {16'd0, flush_thr_reg} ||
                        wear_ticks >= idle_thr_reg) begin
                        wear_flushing     = 1'b1;
                        wear_ticks        = '0;
                        res.flush_request = 1'b1;
                        requests_predicted++;
                    end
                end
            end
            CMD_FLUSH_RESULT: begin
                if (wear_flushing) begin
                    if (it.ok_flag) begin
                        wear_unsaved = '0;
                    end else begin
                        wear_loaded = 1'b0;
                    end
                    wear_flushing = 1'b0;
                    wear_ticks    = '0;
                end
            end
            CMD_SPAN_QUERY: begin
                // unit count rounded up in 33 bits so nothing wraps
                rounded = {1'b0, it.span_length} + 33'((64'd1 << USZ) - 1);
                first = unit;
                stop = first + 64'(rounded >> USZ);
                if (stop > UNITS) begin
                    stop = UNITS;
                end
                total = '0;
                for (i = first; i < stop; i++) begin
                    if (wear_counts[i] > res.span_max) begin
                        res.span_max = wear_counts[i];
                    end
                    total = total + {16'd0, wear_counts[i]};
                    if (total > TOTAL_CAP) begin
                        total = TOTAL_CAP;
                    end
                end
                res.span_total = total[TOTAL_W-1:0];
                spans_predicted++;
            end
            default: begin
            end
        endcase
        res.unsaved_count    = wear_unsaved;
        res.counting_enabled = wear_loaded;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // every field random, caller overrides the ones that matter
    function automatic wear_item_t fresh_item(input logic [2:0] cmd);
        wear_item_t it;
        it.cmd         = cmd;
        it.address     = $urandom();
        it.span_length = $urandom();
        it.unit_index  = 8'($urandom());
        it.load_value  = 16'($urandom());
        it.idle_flag   = 1'($urandom());
        it.ok_flag     = 1'($urandom());
        return it;
    endfunction

    function automatic logic [31:0] pick_erase_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return $urandom();
        end
        if (r < 55 && hot_units.size() != 0) begin
            return {12'd0, hot_units[$urandom_range(0, hot_units.size() - 1)],
                    12'($urandom())};
        end
        return {12'd0, 8'($urandom()), 12'($urandom())};
    endfunction

    function automatic logic [15:0] pick_load_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return NEVER_COUNTED;
        if (r < 35) return COUNT_CAP;
        if (r < 50) return 16'($urandom_range(16'hFFF0, 16'hFFFD));
        if (r < 65) return 16'd0;
        return 16'($urandom());
    endfunction

    function automatic wear_item_t span_item();
        wear_item_t it;
        int r;
        it = fresh_item(CMD_SPAN_QUERY);
        r = $urandom_range(0, 99);
        if (r < 40) begin
            it.address     = {12'd0, 20'($urandom())};
            it.span_length = $urandom_range(0, 8 << USZ);
        end else if (r < 55 && hot_units.size() != 0) begin
            it.address     = {12'd0, hot_units[$urandom_range(0, hot_units.size() - 1)],
                              12'($urandom())};
            it.span_length = $urandom_range(1, 1 << USZ);
        end else if (r < 70) begin
            it.address     = {12'd0, 20'($urandom_range(0, 4095))};
            it.span_length = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end else if (r < 85) begin
            it.address     = {12'd0, 20'($urandom())};
            it.span_length = $urandom_range(0, 32'h0010_0000);
        end
        return it;
    endfunction

    // hand one transaction to the dut and book its expected result
    task automatic issue_command(input wear_item_t it);
        int gap;
        if (tx_calm_left > 0) begin
            tx_calm_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) begin
                tx_calm_left = $urandom_range(10, 40);
            end
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        due_results.push_back(predict_wear(it));
        s_valid       <= 1'b1;
        s_cmd         <= it.cmd;
        s_address     <= it.address;
        s_span_length <= it.span_length;
        s_unit_index  <= it.unit_index;
        s_load_value  <= it.load_value;
        s_idle_flag   <= it.idle_flag;
        s_ok_flag     <= it.ok_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // both thresholds in back-to-back cycles, idle upper bits are junk
    task automatic program_thresholds(input logic [15:0] flush_thr,
                                      input logic [7:0] idle_thr);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_IDX_FLUSH_THR;
        cfg_wr_data <= flush_thr;
        @(posedge aclk);
        cfg_index   <= CFG_IDX_IDLE_THR;
        cfg_wr_data <= {8'($urandom()), idle_thr};
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        flush_thr_reg = flush_thr;
        idle_thr_reg  = idle_thr;
    endtask

    task automatic issue_random_activity();
        wear_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (wear_flushing && $urandom_range(0, 2) == 0) begin
            it = fresh_item(CMD_FLUSH_RESULT);
            it.ok_flag = ($urandom_range(0, 4) != 0);
        end else if (r < 45) begin
            it = fresh_item(CMD_COUNT_ERASE);
            it.address = pick_erase_address();
        end else if (r < 70) begin
            it = fresh_item(CMD_FLUSH_VISIT);
            it.idle_flag = ($urandom_range(0, 3) != 0);
        end else if (r < 75) begin
            it = fresh_item(CMD_FLUSH_RESULT);
        end else if (r < 88) begin
            it = span_item();
        end else if (r < 93) begin
            it = fresh_item(CMD_LOAD_ENTRY);
            it.load_value = pick_load_value();
        end else if (r < 96) begin
            it = fresh_item(CMD_LOAD_DONE);
        end else begin
            it = fresh_item(CMD_UNUSED);
        end
        issue_command(it);
    endtask

    // sessions of an occasional clear, load, commit, then mixed erase, flush, span and load traffic
    task automatic run_random_phase(input logic [15:0] flush_thr,
                                    input logic [7:0] idle_thr, input int n_items);
        wear_item_t it;
        int sent;
        drain_results();
        program_thresholds(flush_thr, idle_thr);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                issue_command(fresh_item(CMD_CLEAR));
                sent++;
            end
            hot_units.delete();
            repeat ($urandom_range(1, 10)) begin
                it = fresh_item(CMD_LOAD_ENTRY);
                it.load_value = pick_load_value();
                hot_units.push_back(it.unit_index);
                issue_command(it);
                sent++;
            end
            it = fresh_item(CMD_LOAD_DONE);
            it.ok_flag = ($urandom_range(0, 9) != 0);
            issue_command(it);
            sent++;
            repeat ($urandom_range(10, 40)) begin
                issue_random_activity();
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_power_up_state();
        wear_item_t it;
        it = fresh_item(CMD_SPAN_QUERY);
        it.address = '0;
        it.span_length = 32'hFFFF_FFFF;
        issue_command(it);
        // nothing loaded yet: erase and visit do nothing
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = 32'h0000_0000;
        issue_command(it);
        it = fresh_item(CMD_FLUSH_VISIT);
        it.idle_flag = 1'b1;
        issue_command(it);
        issue_command(fresh_item(CMD_UNUSED));
    endtask

    task automatic test_load_and_saturation();
        wear_item_t it;
        it = fresh_item(CMD_LOAD_ENTRY);
        it.unit_index = 8'd0;
        it.load_value = NEVER_COUNTED;
        issue_command(it);
        it.unit_index = 8'd255;
        it.load_value = 16'hFFFD;
        issue_command(it);
        it.unit_index = 8'd1;
        it.load_value = COUNT_CAP;
        issue_command(it);
        it.unit_index = 8'd128;
        it.load_value = 16'h1234;
        issue_command(it);
        it = fresh_item(CMD_LOAD_DONE);
        it.ok_flag = 1'b1;
        issue_command(it);
        // last unit climbs to the cap and stays there
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = 32'h000F_F000 | 32'($urandom_range(0, 4095));
        issue_command(it);
        issue_command(it);
        it.address = 32'h0000_1ABC;
        issue_command(it);
        // beyond the table
        it.address = 32'hFFFF_FFFF;
        issue_command(it);
        // spans: empty, single unit, start out of range, whole table
        it = fresh_item(CMD_SPAN_QUERY);
        it.address = '0;
        it.span_length = '0;
        issue_command(it);
        it.address = 32'h000F_F123;
        it.span_length = 32'd1;
        issue_command(it);
        it.address = 32'hFFFF_FFFF;
        it.span_length = 32'hFFFF_FFFF;
        issue_command(it);
        it.address = '0;
        it.span_length = 32'hFFFF_FFFF;
        issue_command(it);
    endtask

    task automatic test_write_back_handshake();
        wear_item_t visit;
        wear_item_t it;
        drain_results();
        program_thresholds(16'd5, 8'd2);
        visit = fresh_item(CMD_FLUSH_VISIT);
        // idle run broken by a busy visit, then reaches the idle limit
        visit.idle_flag = 1'b1;
        issue_command(visit);
        visit.idle_flag = 1'b0;
        issue_command(visit);
        visit.idle_flag = 1'b1;
        issue_command(visit);
        issue_command(visit);
        // write-back pending: visit blocked, erase still counted
        issue_command(visit);
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = 32'h0000_5000 | 32'($urandom_range(0, 4095));
        issue_command(it);
        // failed write-back, then a result with nothing pending
        it = fresh_item(CMD_FLUSH_RESULT);
        it.ok_flag = 1'b0;
        issue_command(it);
        it.ok_flag = 1'b1;
        issue_command(it);
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = 32'h0000_5000;
        issue_command(it);
        // failed commit wipes the table, then a good one
        it = fresh_item(CMD_LOAD_DONE);
        it.ok_flag = 1'b0;
        issue_command(it);
        it.ok_flag = 1'b1;
        issue_command(it);
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = 32'h0000_7FFF;
        issue_command(it);
        // erase limit reached on a busy visit, write-back succeeds
        visit.idle_flag = 1'b0;
        issue_command(visit);
        it = fresh_item(CMD_FLUSH_RESULT);
        it.ok_flag = 1'b1;
        issue_command(it);
        visit.idle_flag = 1'b1;
        issue_command(visit);
        issue_command(fresh_item(CMD_CLEAR));
    endtask

    task automatic test_idle_limit_top();
        wear_item_t it;
        drain_results();
        program_thresholds(16'hFFFF, 8'hFF);
        it = fresh_item(CMD_LOAD_DONE);
        it.ok_flag = 1'b1;
        issue_command(it);
        it = fresh_item(CMD_COUNT_ERASE);
        it.address = {12'd0, 20'($urandom())};
        issue_command(it);
        // 255 idle visits in a row raise the request, the rest are blocked
        repeat (258) begin
            it = fresh_item(CMD_FLUSH_VISIT);
            it.idle_flag = 1'b1;
            issue_command(it);
        end
        it = fresh_item(CMD_FLUSH_RESULT);
        it.ok_flag = 1'b1;
        issue_command(it);
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'd1, 8'd1, 120);
        run_random_phase(16'($urandom_range(2, 12)), 8'($urandom_range(2, 10)), 150);
        run_random_phase(16'hFFFF, 8'd3, 120);
        run_random_phase(16'd0, 8'd0, 80);
        run_random_phase(16'($urandom_range(1, 200)), 8'($urandom_range(1, 30)), 150);
    endtask

    // ---------------------------------------------------------------
    // result checking and receiver stalls
    // ---------------------------------------------------------------

    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b1;
            rx_stall_left = 0;
        end else if (m_valid && m_ready) begin
            got = {m_flush_request, m_span_max, m_span_total, m_unsaved_count,
                   m_counting_enabled};
            if (due_results.size() == 0) begin
                $display("%0t ns: result transaction with nothing pending, got %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                results_checked++;
                report_field("flush_request", want.flush_request, got.flush_request);
                report_field("span_max", want.span_max, got.span_max);
                report_field("span_total", want.span_total, got.span_total);
                report_field("unsaved_count", want.unsaved_count, got.unsaved_count);
                report_field("counting_enabled", want.counting_enabled,
                             got.counting_enabled);
            end
            // stall before the next transaction, with calm stretches
            if (rx_calm_left > 0) begin
                rx_calm_left--;
                rx_stall = 0;
            end else begin
                rx_stall = $urandom_range(0, 13);
                if ($urandom_range(0, 39) == 0) begin
                    rx_calm_left = $urandom_range(10, 40);
                end
            end
            if (rx_stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                rx_stall_left = rx_stall;
            end
        end else if (rx_stall_left != 0) begin
            if (rx_stall_left == 1) begin
                m_ready <= 1'b1;
            end
            rx_stall_left--;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        mismatch_count     = 0;
        results_checked    = 0;
        requests_predicted = 0;
        spans_predicted    = 0;
        tx_calm_left       = 0;
        rx_calm_left       = 0;
        rx_stall_left      = 0;
        wipe_wear_counts();
        wear_unsaved  = '0;
        wear_ticks    = '0;
        wear_loaded   = 1'b0;
        wear_flushing = 1'b0;
        flush_thr_reg = FLUSH_THR_RST;
        idle_thr_reg  = IDLE_THR_RST;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_up_state();
        test_load_and_saturation();
        test_write_back_handshake();
        test_idle_limit_top();
        test_random_traffic();

        drain_results();
        repeat (16) @(posedge aclk);
        $display("%0d results checked, %0d write-back requests and %0d span queries seen",
                 results_checked, requests_predicted, spans_predicted);
        $display("thresholds swept from 0 to full scale with random stalls on both sides");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
